>>> rtl/core/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared constants, codes and types of the bucketed priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bpq_pkg;

    // default sizing of the queue
    localparam int PRIORITY_LEVELS_DEF = 10;
    localparam int CAPACITY_DEF        = 64;
    localparam int ELEM_WIDTH_DEF      = 32;

    // fixed field widths
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 2;

    // reset value of the lowest accepted priority
    localparam logic [PRIO_W-1:0] LOWEST_PRIO_RST = 4'd9;

    // operation codes
    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_PRIO_RANGE = 2'd1,
        ST_FULL       = 2'd2,
        ST_EMPTY      = 2'd3
    } status_t;

    // what the entry ram read data of this cycle belongs to
    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_REFILL = 2'd1,
        PEND_FREE   = 2'd2
    } pend_t;

endpackage

`default_nettype wire

>>> rtl/core/bpq_entry_ram.sv
// ----------------------------------------------------------------------------
// bpq_entry_ram
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpq_entry_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 39
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write first in code order, read returns the old contents
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/bucketed_priority_queue_top.sv
// ----------------------------------------------------------------------------
// bucketed_priority_queue_top
// Priority queue with one LIFO bucket per priority level, 0 most urgent.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  cfg       in         cfg_wr_en          cfg_wr_data (lowest_priority)
//  s_        in         s_valid/s_ready    s_op, s_elem_value, s_prio
//  m_        out        m_valid/m_ready    m_status, m_head_value, m_head_prio,
//                                          m_count, m_is_empty
//
//  one item per cycle sustained while results are taken; the result follows
//  the input register, then one update pass into the result register.
//  bucket heads and second entries sit in registers; deeper entries and the
//  free list live in the entry ram, its one read per item absorbed next cycle.
//  synchronous active-low reset, no clearing pass: a fill counter hands out
//  unused slots. a stalled result holds the input register and s_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module bucketed_priority_queue_top #(
    parameter int PRIORITY_LEVELS = bpq_pkg::PRIORITY_LEVELS_DEF,
    parameter int CAPACITY        = bpq_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH      = bpq_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bpq_pkg::PRIO_W-1:0]      cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_op,
    input  wire logic [ELEM_WIDTH-1:0]           s_elem_value,
    input  wire logic [bpq_pkg::PRIO_W-1:0]      s_prio,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [bpq_pkg::STATUS_W-1:0]         m_status,
    output logic [ELEM_WIDTH-1:0]                m_head_value,
    output logic [bpq_pkg::PRIO_W-1:0]           m_head_prio,
    output logic [$clog2(CAPACITY+1)-1:0]        m_count,
    output logic                                 m_is_empty
);

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY+1);
    localparam int BKT_W   = $clog2(PRIORITY_LEVELS);
    localparam int ENTRY_W = ELEM_WIDTH + SLOT_W + 1;
    localparam int PL      = PRIORITY_LEVELS;

    // configuration
    logic [bpq_pkg::PRIO_W-1:0] lowest_prio_reg;

    // input register
    logic                       in_valid_reg;
    bpq_pkg::op_t               in_op_reg;
    logic [ELEM_WIDTH-1:0]      in_elem_reg;
    logic [bpq_pkg::PRIO_W-1:0] in_prio_reg;

    // result register
    logic                       out_valid_reg;
    bpq_pkg::status_t           out_status_reg, out_status_next;
    logic [ELEM_WIDTH-1:0]      out_value_reg, out_value_next;
    logic [bpq_pkg::PRIO_W-1:0] out_prio_reg, out_prio_next;
    logic [CNT_W-1:0]           out_count_reg;
    logic                       out_empty_reg;

    // per-bucket head and second entry
    logic [PL-1:0]         head_valid_reg, head_valid_next;
    logic [ELEM_WIDTH-1:0] head_value_reg [PL];
    logic [ELEM_WIDTH-1:0] head_value_next [PL];
    logic [PL-1:0]         sec_valid_reg, sec_valid_next;
    logic [ELEM_WIDTH-1:0] sec_value_reg [PL];
    logic [ELEM_WIDTH-1:0] sec_value_next [PL];
    logic [SLOT_W-1:0]     sec_link_reg [PL];
    logic [SLOT_W-1:0]     sec_link_next [PL];
    logic [PL-1:0]         sec_more_reg, sec_more_next;

    // second entry with a pending refill folded in
    logic [ELEM_WIDTH-1:0] sec_value_eff [PL];
    logic [SLOT_W-1:0]     sec_link_eff [PL];
    logic [PL-1:0]         sec_more_eff;

    // slot pool and counters
    logic [SLOT_W-1:0] free_top_reg, free_top_next, free_top_eff;
    logic [CNT_W-1:0]  free_len_reg, free_len_next;
    logic [CNT_W-1:0]  fresh_reg, fresh_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    bpq_pkg::pend_t    pend_reg, pend_next;
    logic [BKT_W-1:0]  pend_bkt_reg, pend_bkt_next;

    // entry ram port signals
    logic               mem_we, mem_re;
    logic [SLOT_W-1:0]  mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
    logic [ELEM_WIDTH-1:0] rd_value;
    logic [SLOT_W-1:0]     rd_link;
    logic                  rd_last;

    // decode
    logic                  go;
    logic                  prio_bad, full, empty, enq_ok, deq_ok;
    logic [BKT_W-1:0]      found_cur;
    logic                  any_cur;
    logic [PL-1:0]         sel;
    logic                  t_head_valid, t_sec_valid, t_sec_more;
    logic [ELEM_WIDTH-1:0] t_sec_value;
    logic [SLOT_W-1:0]     t_sec_link;
    logic [SLOT_W-1:0]     alloc_slot;

    bpq_entry_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_W)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign rd_value = mem_rdata[ENTRY_W-1 -: ELEM_WIDTH];
    assign rd_link  = mem_rdata[SLOT_W:1];
    assign rd_last  = mem_rdata[0];

    // handshake
    assign go      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || go;

    // fold the previous cycle's ram read into bucket and pool state
    always_comb begin
        for (int b = 0; b < PL; b++) begin
            sec_value_eff[b] = sec_value_reg[b];
            sec_link_eff[b]  = sec_link_reg[b];
            sec_more_eff[b]  = sec_more_reg[b];
            if (pend_reg == bpq_pkg::PEND_REFILL && pend_bkt_reg == BKT_W'(b)) begin
                sec_value_eff[b] = rd_value;
                sec_link_eff[b]  = rd_link;
                sec_more_eff[b]  = !rd_last;
            end
        end
        free_top_eff = (pend_reg == bpq_pkg::PEND_FREE) ? rd_link : free_top_reg;
    end

    // most urgent non-empty bucket before the update
    always_comb begin
        found_cur = '0;
        for (int b = PL - 1; b >= 0; b--) begin
            if (head_valid_reg[b]) begin
                found_cur = BKT_W'(b);
            end
        end
        any_cur = |head_valid_reg;
    end

    // item checks
    assign prio_bad = (in_prio_reg > lowest_prio_reg) || (32'(in_prio_reg) >= 32'(PL));
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign enq_ok   = (in_op_reg == bpq_pkg::OP_ENQ) && !prio_bad && !full;
    assign deq_ok   = (in_op_reg == bpq_pkg::OP_DEQ) && !empty;

    // target bucket and its entries
    always_comb begin
        t_sec_value = '0;
        t_sec_link  = '0;
        t_sec_more  = 1'b0;
        for (int b = 0; b < PL; b++) begin
            if (in_op_reg == bpq_pkg::OP_ENQ) begin
                sel[b] = (32'(in_prio_reg) == b);
            end else begin
                sel[b] = any_cur && (found_cur == BKT_W'(b));
            end
        end
        for (int b = 0; b < PL; b++) begin
            if (sel[b]) begin
                t_sec_value = t_sec_value | sec_value_eff[b];
                t_sec_link  = t_sec_link | sec_link_eff[b];
                t_sec_more  = t_sec_more | sec_more_eff[b];
            end
        end
        t_head_valid = |(sel & head_valid_reg);
        t_sec_valid  = |(sel & sec_valid_reg);
    end

    // slot for an entry pushed down into the ram
    assign alloc_slot = (free_len_reg != '0) ? free_top_eff : fresh_reg[SLOT_W-1:0];

    // queue update
    always_comb begin
        head_valid_next = head_valid_reg;
        sec_valid_next  = sec_valid_reg;
        sec_more_next   = sec_more_eff;
        for (int b = 0; b < PL; b++) begin
            head_value_next[b] = head_value_reg[b];
            sec_value_next[b]  = sec_value_eff[b];
            sec_link_next[b]   = sec_link_eff[b];
        end
        free_top_next   = free_top_eff;
        free_len_next   = free_len_reg;
        fresh_next      = fresh_reg;
        count_next      = count_reg;
        pend_next       = bpq_pkg::PEND_NONE;
        pend_bkt_next   = pend_bkt_reg;
        mem_we          = 1'b0;
        mem_waddr       = alloc_slot;
        mem_wdata       = {t_sec_value, t_sec_link, !t_sec_more};
        mem_re          = 1'b0;
        mem_raddr       = alloc_slot;
        out_status_next = bpq_pkg::ST_OK;

        if (in_op_reg == bpq_pkg::OP_ENQ) begin
            if (prio_bad) begin
                out_status_next = bpq_pkg::ST_PRIO_RANGE;
            end else if (full) begin
                out_status_next = bpq_pkg::ST_FULL;
            end
        end else if (empty) begin
            out_status_next = bpq_pkg::ST_EMPTY;
        end

        if (go && enq_ok) begin
            // push at bucket head, old head becomes second
            count_next = count_reg + CNT_W'(1);
            for (int b = 0; b < PL; b++) begin
                if (sel[b]) begin
                    head_value_next[b] = in_elem_reg;
                    head_valid_next[b] = 1'b1;
                    if (head_valid_reg[b]) begin
                        sec_valid_next[b] = 1'b1;
                        sec_value_next[b] = head_value_reg[b];
                        sec_more_next[b]  = sec_valid_reg[b];
                        sec_link_next[b]  = alloc_slot;
                    end
                end
            end
            // old second moves into the ram
            if (t_head_valid && t_sec_valid) begin
                mem_we = 1'b1;
                if (free_len_reg != '0) begin
                    free_len_next = free_len_reg - CNT_W'(1);
                    if (free_len_reg > CNT_W'(1)) begin
                        mem_re    = 1'b1;
                        mem_raddr = alloc_slot;
                        pend_next = bpq_pkg::PEND_FREE;
                    end
                end else begin
                    fresh_next = fresh_reg + CNT_W'(1);
                end
            end
        end else if (go && deq_ok) begin
            // pop bucket head, second moves up
            count_next = count_reg - CNT_W'(1);
            for (int b = 0; b < PL; b++) begin
                if (sel[b]) begin
                    if (sec_valid_reg[b]) begin
                        head_value_next[b] = sec_value_eff[b];
                        sec_valid_next[b]  = sec_more_eff[b];
                    end else begin
                        head_valid_next[b] = 1'b0;
                    end
                end
            end
            // third entry refills second, its slot returns to the pool
            if (t_sec_valid && t_sec_more) begin
                mem_re        = 1'b1;
                mem_raddr     = t_sec_link;
                pend_next     = bpq_pkg::PEND_REFILL;
                pend_bkt_next = found_cur;
                mem_we        = 1'b1;
                mem_waddr     = t_sec_link;
                mem_wdata     = {{ELEM_WIDTH{1'b0}}, free_top_eff, 1'b0};
                free_top_next = t_sec_link;
                free_len_next = free_len_reg + CNT_W'(1);
            end
        end
    end

    // head of the most urgent bucket after the update
    always_comb begin
        out_value_next = '0;
        out_prio_next  = '0;
        for (int b = PL - 1; b >= 0; b--) begin
            if (head_valid_next[b]) begin
                out_value_next = head_value_next[b];
                out_prio_next  = bpq_pkg::PRIO_W'(b);
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lowest_prio_reg <= bpq_pkg::LOWEST_PRIO_RST;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            head_valid_reg  <= '0;
            sec_valid_reg   <= '0;
            free_len_reg    <= '0;
            fresh_reg       <= '0;
            count_reg       <= '0;
            pend_reg        <= bpq_pkg::PEND_NONE;
        end else begin
            if (cfg_wr_en) begin
                lowest_prio_reg <= cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (go) begin
                in_valid_reg <= 1'b0;
            end
            if (go) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            head_valid_reg <= head_valid_next;
            sec_valid_reg  <= sec_valid_next;
            free_len_reg   <= free_len_next;
            fresh_reg      <= fresh_next;
            count_reg      <= count_next;
            pend_reg       <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= bpq_pkg::op_t'(s_op);
            in_elem_reg <= s_elem_value;
            in_prio_reg <= s_prio;
        end
        if (go) begin
            out_status_reg <= out_status_next;
            out_value_reg  <= out_value_next;
            out_prio_reg   <= out_prio_next;
            out_count_reg  <= count_next;
            out_empty_reg  <= (count_next == '0);
        end
        for (int b = 0; b < PL; b++) begin
            head_value_reg[b] <= head_value_next[b];
            sec_value_reg[b]  <= sec_value_next[b];
            sec_link_reg[b]   <= sec_link_next[b];
        end
        sec_more_reg <= sec_more_next;
        free_top_reg <= free_top_next;
        pend_bkt_reg <= pend_bkt_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_head_value = out_value_reg;
    assign m_head_prio  = out_prio_reg;
    assign m_count      = out_count_reg;
    assign m_is_empty   = out_empty_reg;

`ifndef SYNTHESIS
    // stored count stays within the pool
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("stored count above capacity");

    // a zero count and an all-empty bucket set go together
    a_count_heads: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) == (head_valid_reg == '0))
        else $error("count disagrees with bucket heads");

    // a bucket never holds a second entry without a head
    a_second_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (sec_valid_reg & ~head_valid_reg) == '0)
        else $error("second entry without head");

    // recycled slots never outnumber slots handed out
    a_pool_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_len_reg <= fresh_reg)
        else $error("free list longer than used slots");
`endif

endmodule

`default_nettype wire
